@@ rtl/cle_pkg.sv @@
// shared types and constants for the console line editor
`default_nettype none

package cle_pkg;

    localparam int LINE_DEPTH  = 16;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int FILL_W      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic [7:0]        byte_t;
    typedef logic [1:0]        kind_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam kind_t KIND_ECHO = 2'd0;
    localparam kind_t KIND_LINE = 2'd1;
    localparam kind_t KIND_END  = 2'd2;

    localparam byte_t CH_NUL   = 8'd0;
    localparam byte_t CH_ETX   = 8'd3;
    localparam byte_t CH_BEL   = 8'd7;
    localparam byte_t CH_BS    = 8'd8;
    localparam byte_t CH_LF    = 8'd10;
    localparam byte_t CH_CR    = 8'd13;
    localparam byte_t CH_DC2   = 8'd18;
    localparam byte_t CH_NAK   = 8'd21;
    localparam byte_t CH_ETB   = 8'd23;
    localparam byte_t CH_SPACE = 8'd32;
    localparam byte_t CH_C     = 8'd67;
    localparam byte_t CH_R     = 8'd82;
    localparam byte_t CH_CARET = 8'd94;
    localparam byte_t CH_TILDE = 8'd126;
    localparam byte_t CH_DEL   = 8'd127;

    localparam fill_t LIMIT_RESET = 5'd16;

    typedef enum logic [2:0] {
        CMD_NEWLINE,
        CMD_PRINT,
        CMD_ERASE,
        CMD_CANCEL,
        CMD_REPRINT,
        CMD_KILL,
        CMD_WORD,
        CMD_BEEP
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE,
        S_BEEP,
        S_NL_ECHO,
        S_NL_LINE,
        S_NL_END,
        S_CANCEL,
        S_RP_HEAD,
        S_RP_LINE,
        S_ERASE
    } st_t;

    typedef struct packed {
        cmd_t  cmd;
        byte_t ch;
    } q_entry_t;

endpackage

`default_nettype wire

@@ rtl/cle_if.sv @@
// valid/ready channel interfaces for typed bytes and result items
`default_nettype none

interface cle_key_if;
    logic           valid;
    logic           ready;
    cle_pkg::byte_t typed_byte;

    modport source (output valid, output typed_byte, input ready);
    modport sink   (input valid, input typed_byte, output ready);
endinterface

interface cle_result_if;
    logic           valid;
    logic           ready;
    cle_pkg::kind_t kind;
    cle_pkg::byte_t data_byte;
    logic           cancelled;
    logic           last;

    modport source (output valid, output kind, output data_byte, output cancelled,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input cancelled,
                    input last, output ready);
endinterface

`default_nettype wire

@@ rtl/cle_front.sv @@
// front end: accepts typed bytes and classifies them into editor commands
`default_nettype none

module cle_front (
    cle_key_if.sink             keys,
    input  wire logic           full,
    output logic                push,
    output cle_pkg::q_entry_t   entry
);

    cle_pkg::cmd_t cmd;

    always_comb
    begin
        unique case (keys.typed_byte) inside
            cle_pkg::CH_LF, cle_pkg::CH_CR:        cmd = cle_pkg::CMD_NEWLINE;
            cle_pkg::CH_BS, cle_pkg::CH_DEL:       cmd = cle_pkg::CMD_ERASE;
            cle_pkg::CH_ETX:                       cmd = cle_pkg::CMD_CANCEL;
            cle_pkg::CH_DC2:                       cmd = cle_pkg::CMD_REPRINT;
            cle_pkg::CH_NAK:                       cmd = cle_pkg::CMD_KILL;
            cle_pkg::CH_ETB:                       cmd = cle_pkg::CMD_WORD;
            [cle_pkg::CH_SPACE:cle_pkg::CH_TILDE]: cmd = cle_pkg::CMD_PRINT;
            default:                               cmd = cle_pkg::CMD_BEEP;
        endcase
    end

    assign keys.ready = !full;
    assign push       = keys.valid && !full;
    assign entry.cmd  = cmd;
    assign entry.ch   = keys.typed_byte;

endmodule

`default_nettype wire

@@ rtl/cle_queue.sv @@
// short command queue between front end and back end
`default_nettype none

module cle_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cle_pkg::q_entry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output cle_pkg::q_entry_t       head
);

    cle_pkg::q_entry_t                slot_reg [cle_pkg::QUEUE_DEPTH];
    logic [cle_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cle_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cle_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign full    = count_reg == cle_pkg::QCNT_W'(cle_pkg::QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cle_back.sv @@
// back end: line buffer, edit sequencer and registered result output
`default_nettype none

module cle_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire cle_pkg::fill_t     cfg_wdata,
    input  wire logic               q_valid,
    input  wire cle_pkg::q_entry_t  q_head,
    output logic                    q_pop,
    cle_result_if.source            results
);

    cle_pkg::st_t    state_reg, state_next;
    cle_pkg::cmd_t   cmd_reg, cmd_next;
    cle_pkg::byte_t  ch_reg, ch_next;
    cle_pkg::fill_t  fill_reg, fill_next;
    cle_pkg::addr_t  idx_reg, idx_next;
    logic [1:0]      phase_reg, phase_next;
    logic            word_reg, word_next;
    cle_pkg::fill_t  limit_reg;

    cle_pkg::byte_t  store_reg [cle_pkg::LINE_DEPTH];
    logic            store_we;

    logic            res_valid_reg;
    cle_pkg::kind_t  res_kind_reg;
    cle_pkg::byte_t  res_data_reg;
    logic            res_cancel_reg;
    logic            res_last_reg;

    logic            emit;
    cle_pkg::kind_t  emit_kind;
    cle_pkg::byte_t  emit_data;
    logic            emit_cancel;
    logic            emit_last;
    logic            out_free;

    cle_pkg::fill_t  size, room, fill_dec, fill_m2;
    cle_pkg::addr_t  rd_addr;
    cle_pkg::byte_t  rd_data;
    logic            top_space;
    logic            erase_more;
    logic            idx_at_end;

    assign out_free  = !res_valid_reg || results.ready;
    assign size      = (limit_reg < cle_pkg::FILL_W'(cle_pkg::LINE_DEPTH))
                       ? limit_reg : cle_pkg::FILL_W'(cle_pkg::LINE_DEPTH);
    assign room      = (size != '0) ? size - 1'b1 : '0;
    assign fill_dec  = fill_reg - 1'b1;
    assign fill_m2   = fill_reg - 2'd2;
    assign rd_data   = store_reg[rd_addr];
    assign top_space = rd_data == cle_pkg::CH_SPACE;
    assign idx_at_end = {1'b0, idx_reg} == fill_dec;
    assign erase_more = (fill_dec != '0)
                        && ((cmd_reg == cle_pkg::CMD_KILL)
                            || (cmd_reg == cle_pkg::CMD_WORD && !(word_reg && top_space)));

    always_comb
    begin
        unique case (state_reg)
            cle_pkg::S_ERASE:                      rd_addr = fill_m2[cle_pkg::ADDR_W-1:0];
            cle_pkg::S_NL_LINE, cle_pkg::S_RP_LINE: rd_addr = idx_reg;
            default:                               rd_addr = fill_dec[cle_pkg::ADDR_W-1:0];
        endcase
    end

    // next state and sequencing counters
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ch_next    = ch_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        word_next  = word_reg;
        q_pop      = 1'b0;
        store_we   = 1'b0;
        unique case (state_reg)
            cle_pkg::S_IDLE:
            begin
                phase_next = '0;
                idx_next   = '0;
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_head.cmd;
                    ch_next   = q_head.ch;
                    word_next = !top_space;
                    unique case (q_head.cmd)
                        cle_pkg::CMD_NEWLINE: state_next = cle_pkg::S_NL_ECHO;
                        cle_pkg::CMD_PRINT:
                            state_next = (fill_reg < room) ? cle_pkg::S_STORE : cle_pkg::S_BEEP;
                        cle_pkg::CMD_ERASE:
                            state_next = (fill_reg != '0) ? cle_pkg::S_ERASE : cle_pkg::S_BEEP;
                        cle_pkg::CMD_CANCEL:  state_next = cle_pkg::S_CANCEL;
                        cle_pkg::CMD_REPRINT: state_next = cle_pkg::S_RP_HEAD;
                        cle_pkg::CMD_KILL, cle_pkg::CMD_WORD:
                            state_next = (fill_reg != '0) ? cle_pkg::S_ERASE : cle_pkg::S_IDLE;
                        default:              state_next = cle_pkg::S_BEEP;
                    endcase
                end
            end
            cle_pkg::S_STORE:
            begin
                if (out_free)
                begin
                    store_we   = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    state_next = cle_pkg::S_IDLE;
                end
            end
            cle_pkg::S_BEEP:
            begin
                if (out_free)
                begin
                    state_next = cle_pkg::S_IDLE;
                end
            end
            cle_pkg::S_NL_ECHO:
            begin
                if (out_free)
                begin
                    state_next = (fill_reg != '0) ? cle_pkg::S_NL_LINE : cle_pkg::S_NL_END;
                end
            end
            cle_pkg::S_NL_LINE:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_at_end)
                    begin
                        state_next = cle_pkg::S_NL_END;
                    end
                end
            end
            cle_pkg::S_NL_END:
            begin
                if (out_free)
                begin
                    fill_next  = '0;
                    state_next = cle_pkg::S_IDLE;
                end
            end
            cle_pkg::S_CANCEL:
            begin
                if (out_free)
                begin
                    phase_next = phase_reg + 1'b1;
                    if (phase_reg == 2'd3)
                    begin
                        fill_next  = '0;
                        state_next = cle_pkg::S_IDLE;
                    end
                end
            end
            cle_pkg::S_RP_HEAD:
            begin
                if (out_free)
                begin
                    phase_next = phase_reg + 1'b1;
                    if (phase_reg == 2'd2)
                    begin
                        phase_next = '0;
                        state_next = (fill_reg != '0) ? cle_pkg::S_RP_LINE : cle_pkg::S_IDLE;
                    end
                end
            end
            cle_pkg::S_RP_LINE:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_at_end)
                    begin
                        state_next = cle_pkg::S_IDLE;
                    end
                end
            end
            cle_pkg::S_ERASE:
            begin
                if (out_free)
                begin
                    phase_next = phase_reg + 1'b1;
                    if (phase_reg == 2'd2)
                    begin
                        phase_next = '0;
                        fill_next  = fill_dec;
                        word_next  = word_reg || !top_space;
                        if (!erase_more)
                        begin
                            state_next = cle_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = cle_pkg::S_IDLE;
            end
        endcase
    end

    // result item for the current step
    always_comb
    begin
        emit        = 1'b1;
        emit_kind   = cle_pkg::KIND_ECHO;
        emit_data   = cle_pkg::CH_NUL;
        emit_cancel = 1'b0;
        emit_last   = 1'b0;
        unique case (state_reg)
            cle_pkg::S_IDLE:
            begin
                emit = 1'b0;
            end
            cle_pkg::S_STORE:
            begin
                emit_data = ch_reg;
                emit_last = 1'b1;
            end
            cle_pkg::S_BEEP:
            begin
                emit_data = cle_pkg::CH_BEL;
                emit_last = 1'b1;
            end
            cle_pkg::S_NL_ECHO:
            begin
                emit_data = cle_pkg::CH_LF;
            end
            cle_pkg::S_NL_LINE:
            begin
                emit_kind = cle_pkg::KIND_LINE;
                emit_data = rd_data;
            end
            cle_pkg::S_NL_END:
            begin
                emit_kind = cle_pkg::KIND_END;
                emit_last = 1'b1;
            end
            cle_pkg::S_CANCEL:
            begin
                unique case (phase_reg)
                    2'd0: emit_data = cle_pkg::CH_CARET;
                    2'd1: emit_data = cle_pkg::CH_C;
                    2'd2: emit_data = cle_pkg::CH_LF;
                    default:
                    begin
                        emit_kind   = cle_pkg::KIND_END;
                        emit_cancel = 1'b1;
                        emit_last   = 1'b1;
                    end
                endcase
            end
            cle_pkg::S_RP_HEAD:
            begin
                unique case (phase_reg)
                    2'd0:    emit_data = cle_pkg::CH_CARET;
                    2'd1:    emit_data = cle_pkg::CH_R;
                    default:
                    begin
                        emit_data = cle_pkg::CH_LF;
                        emit_last = fill_reg == '0;
                    end
                endcase
            end
            cle_pkg::S_RP_LINE:
            begin
                emit_data = rd_data;
                emit_last = idx_at_end;
            end
            cle_pkg::S_ERASE:
            begin
                unique case (phase_reg)
                    2'd1:    emit_data = cle_pkg::CH_SPACE;
                    2'd2:
                    begin
                        emit_data = cle_pkg::CH_BS;
                        emit_last = !erase_more;
                    end
                    default: emit_data = cle_pkg::CH_BS;
                endcase
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cle_pkg::S_IDLE;
            cmd_reg       <= cle_pkg::CMD_BEEP;
            fill_reg      <= '0;
            idx_reg       <= '0;
            phase_reg     <= '0;
            word_reg      <= 1'b0;
            limit_reg     <= cle_pkg::LIMIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            word_reg  <= word_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (emit && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        if (emit && out_free)
        begin
            res_kind_reg   <= emit_kind;
            res_data_reg   <= emit_data;
            res_cancel_reg <= emit_cancel;
            res_last_reg   <= emit_last;
        end
        if (store_we)
        begin
            store_reg[fill_reg[cle_pkg::ADDR_W-1:0]] <= ch_reg;
        end
    end

    assign results.valid     = res_valid_reg;
    assign results.kind      = res_kind_reg;
    assign results.data_byte = res_data_reg;
    assign results.cancelled = res_cancel_reg;
    assign results.last      = res_last_reg;

endmodule

`default_nettype wire

@@ rtl/console_line_editor.sv @@
// path: a typed byte is written into the command queue and popped by the back end when it is idle;
//   its results are registered and then leave one per cycle while results.ready stays high
// flow: the queue takes new bytes while the back end is still sequencing an earlier one;
//   the back-end sequencer walks the line buffer one byte a cycle unless the output stalls
// reset: asynchronous, clears the line, the command queue and the output; limit returns to 16
`default_nettype none

module console_line_editor (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire cle_pkg::fill_t  cfg_wdata,
    cle_key_if.sink              keys,
    cle_result_if.source         results
);

    logic               push;
    logic               full;
    logic               q_pop;
    logic               q_valid;
    cle_pkg::q_entry_t  push_entry;
    cle_pkg::q_entry_t  q_head;

    cle_front u_front (
        .keys  (keys),
        .full  (full),
        .push  (push),
        .entry (push_entry)
    );

    cle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    cle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .results   (results)
    );

endmodule

`default_nettype wire

@@ rtl/cle_checker.sv @@
// port-level checks on the result channel, bound to the top level
`default_nettype none

module cle_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            res_valid,
    input wire logic            res_ready,
    input wire cle_pkg::kind_t  res_kind,
    input wire cle_pkg::byte_t  res_data,
    input wire logic            res_cancel,
    input wire logic            res_last
);

    kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_kind == cle_pkg::KIND_ECHO || res_kind == cle_pkg::KIND_LINE
                       || res_kind == cle_pkg::KIND_END))
        else $error("result kind out of range");

    end_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == cle_pkg::KIND_END |-> res_data == cle_pkg::CH_NUL && res_last)
        else $error("end marker not final or carries data");

    cancel_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_cancel |-> res_kind == cle_pkg::KIND_END)
        else $error("cancel flag outside end marker");

    line_never_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == cle_pkg::KIND_LINE |-> !res_last)
        else $error("line byte marked final");

    stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data) && $stable(res_kind))
        else $error("stalled result changed");

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_kind   (results.kind),
    .res_data   (results.data_byte),
    .res_cancel (results.cancelled),
    .res_last   (results.last)
);

`default_nettype wire

@@ verif/line_echo_checker.sv @@
// checker that predicts the echo, line and end items of the console line editor and compares them
`timescale 1ns / 100ps

module line_echo_checker
    import cle_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  fill_t  cfg_wdata,
    cle_key_if     keys,
    cle_result_if  results,
    output int     mismatch_count,
    output int     due_count
);

    typedef struct packed {
        kind_t kind;
        byte_t data_byte;
        logic  cancelled;
        logic  last;
    } edit_item_t;

    byte_t      line_chars [LINE_DEPTH];
    fill_t      char_count;
    fill_t      limit_reg;
    edit_item_t fresh_items[$];
    edit_item_t due_items[$];

    function automatic void emit(kind_t k, byte_t d, logic c);
        edit_item_t r;
        r.kind      = k;
        r.data_byte = d;
        r.cancelled = c;
        r.last      = 1'b0;
        fresh_items.push_back(r);
    endfunction

    function automatic void erase_char();
        emit(KIND_ECHO, CH_BS, 1'b0);
        emit(KIND_ECHO, CH_SPACE, 1'b0);
        emit(KIND_ECHO, CH_BS, 1'b0);
        char_count = char_count - 1'b1;
    endfunction

    function automatic byte_t tail_char();
        return line_chars[addr_t'(char_count - 1'b1)];
    endfunction

    function automatic void edit_line(byte_t ch);
        fill_t size;
        fill_t room;
        size = (limit_reg < fill_t'(LINE_DEPTH)) ? limit_reg : fill_t'(LINE_DEPTH);
        room = (size > 0) ? size - 1'b1 : '0;
        fresh_items.delete();
        if (ch == CH_LF || ch == CH_CR)
        begin
            emit(KIND_ECHO, CH_LF, 1'b0);
            for (int i = 0; i < char_count; i++)
                emit(KIND_LINE, line_chars[i], 1'b0);
            emit(KIND_END, CH_NUL, 1'b0);
            char_count = '0;
        end
        else if (ch >= CH_SPACE && ch <= CH_TILDE && char_count < room)
        begin
            emit(KIND_ECHO, ch, 1'b0);
            line_chars[addr_t'(char_count)] = ch;
            char_count = char_count + 1'b1;
        end
        else if ((ch == CH_BS || ch == CH_DEL) && char_count > 0)
        begin
            erase_char();
        end
        else if (ch == CH_ETX)
        begin
            emit(KIND_ECHO, CH_CARET, 1'b0);
            emit(KIND_ECHO, CH_C, 1'b0);
            emit(KIND_ECHO, CH_LF, 1'b0);
            emit(KIND_END, CH_NUL, 1'b1);
            char_count = '0;
        end
        else if (ch == CH_DC2)
        begin
            emit(KIND_ECHO, CH_CARET, 1'b0);
            emit(KIND_ECHO, CH_R, 1'b0);
            emit(KIND_ECHO, CH_LF, 1'b0);
            for (int i = 0; i < char_count; i++)
                emit(KIND_ECHO, line_chars[i], 1'b0);
        end
        else if (ch == CH_NAK)
        begin
            while (char_count > 0)
                erase_char();
        end
        else if (ch == CH_ETB)
        begin
            while (char_count > 0 && tail_char() == CH_SPACE)
                erase_char();
            while (char_count > 0 && tail_char() != CH_SPACE)
                erase_char();
        end
        else
        begin
            emit(KIND_ECHO, CH_BEL, 1'b0);
        end
        if (fresh_items.size() > 0)
            fresh_items[fresh_items.size() - 1].last = 1'b1;
        foreach (fresh_items[j])
            due_items.push_back(fresh_items[j]);
    endfunction

    function automatic void check_transfer();
        edit_item_t got;
        edit_item_t want;
        got.kind      = results.kind;
        got.data_byte = results.data_byte;
        got.cancelled = results.cancelled;
        got.last      = results.last;
        if (due_items.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result kind %0d data %02h cancelled %0b last %0b",
                     $time, got.kind, got.data_byte, got.cancelled, got.last);
        end
        else
        begin
            want = due_items.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                $display("%0t: result mismatch, expected kind %0d data %02h cancelled %0b last %0b",
                         $time, want.kind, want.data_byte, want.cancelled, want.last);
                $display("%0t:                  actual   kind %0d data %02h cancelled %0b last %0b",
                         $time, got.kind, got.data_byte, got.cancelled, got.last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count     = '0;
            limit_reg      = LIMIT_RESET;
            mismatch_count = 0;
            due_items.delete();
            due_count      = 0;
        end
        else
        begin
            if (results.valid && results.ready)
                check_transfer();
            if (cfg_we)
                limit_reg = cfg_wdata;
            if (keys.valid && keys.ready)
                edit_line(keys.typed_byte);
            due_count = due_items.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// top of the console line editor testbench: clock, reset, key stimulus, result stalls, verdict
`timescale 1ns / 100ps

module testbench;
    import cle_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    fill_t cfg_wdata;
    int    mismatch_count;
    int    results_due;
    int    cycle_count = 0;
    int    hold_cycles = 0;
    bit    calm = 1'b0;
    byte_t script[$];

    cle_key_if    key_ch ();
    cle_result_if res_ch ();

    console_line_editor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .keys      (key_ch),
        .results   (res_ch)
    );

    line_echo_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .keys           (key_ch),
        .results        (res_ch),
        .mismatch_count (mismatch_count),
        .due_count      (results_due)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side: random stalls plus the long hold-off
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (!calm && $urandom_range(0, 99) < 8)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic send_key(input byte_t b);
        @(negedge clk);
        key_ch.valid      <= 1'b1;
        key_ch.typed_byte <= b;
        do @(posedge clk); while (!key_ch.ready);
    endtask

    task automatic key_gap();
        int n;
        if (!calm && $urandom_range(0, 99) < 8)
        begin
            n = $urandom_range(1, 6);
            @(negedge clk);
            key_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic play_script();
        foreach (script[i])
        begin
            send_key(script[i]);
            key_gap();
        end
    endtask

    task automatic drain();
        @(negedge clk);
        key_ch.valid <= 1'b0;
        wait (results_due == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_limit(input fill_t v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic byte_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      return byte_t'($urandom_range(97, 122));
        else if (r < 50) return CH_SPACE;
        else if (r < 56) return byte_t'($urandom_range(33, 126));
        else if (r < 60) return CH_BS;
        else if (r < 63) return CH_DEL;
        else if (r < 65) return CH_NAK;
        else if (r < 70) return CH_ETB;
        else if (r < 73) return CH_DC2;
        else if (r < 78) return CH_CR;
        else if (r < 81) return CH_LF;
        else if (r < 83) return CH_ETX;
        else             return byte_t'($urandom_range(0, 255));
    endfunction

    task automatic run_random(input int n);
        repeat (n)
        begin
            send_key(pick_key());
            key_gap();
        end
    endtask

    initial
    begin
        key_ch.valid      = 1'b0;
        key_ch.typed_byte = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_limit(LIMIT_RESET);
        script = '{CH_BS, CH_NAK, CH_ETB, "A", CH_SPACE, CH_TILDE, "b", CH_SPACE, CH_SPACE,
                   CH_ETB, CH_DC2, CH_DEL, CH_BS, CH_CR, CH_NUL, 8'd31, 8'd128, 8'd255,
                   "x", "y", CH_NAK, "q", CH_ETX, CH_LF, CH_BEL};
        play_script();
        drain();

        // smallest buffers
        set_limit(5'd2);
        script = '{"a", "b", CH_BS, CH_BS, "c", CH_CR};
        play_script();
        drain();
        set_limit(5'd0);
        script = '{"a", CH_DC2, CH_CR};
        play_script();
        drain();
        set_limit(5'd1);
        script = '{"z", CH_ETX};
        play_script();
        drain();

        // limit above the buffer depth
        set_limit(5'd31);
        run_random(40);
        drain();

        // limit lowered under a partly filled line
        set_limit(LIMIT_RESET);
        script = '{CH_ETX, "a", "b", "c", "d", "e", "f", "g", "h", "i", "j"};
        play_script();
        drain();
        set_limit(5'd4);
        script = '{"k", CH_DC2, CH_BS, "m", CH_NAK, "n", "o", "p", "q", CH_CR};
        play_script();
        drain();

        for (int p = 0; p < 5; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                set_limit(fill_t'($urandom_range(0, 31)));
            else
                set_limit(fill_t'($urandom_range(2, 16)));
            @(posedge clk);
            calm = (p == 1);
            if (p == 2)
                hold_cycles = 400;
            run_random(45);
            drain();
            @(posedge clk);
            calm = 1'b0;
        end

        drain();
        repeat (50) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cle_pkg.sv
rtl/cle_if.sv
rtl/cle_front.sv
rtl/cle_queue.sv
rtl/cle_back.sv
rtl/console_line_editor.sv
rtl/cle_checker.sv
verif/line_echo_checker.sv
verif/testbench.sv
